@@ sv/ple_pkg.sv @@
// Shared types, constants and codes for the positional list engine.
package ple_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int POS_W      = 7;
	localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_GET    = 2'd2,
		OP_LOCATE = 2'd3
	} op_e_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_RANGE     = 2'd1,
		STS_FULL      = 2'd2,
		STS_NOT_FOUND = 2'd3
	} status_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Request item.
	typedef struct packed {
		logic [1:0]            kind;
		logic [POS_W-1:0]      position;
		logic [DATA_WIDTH-1:0] value;
	} req_t;

	// Response item.
	typedef struct packed {
		logic [1:0]            status;
		logic [DATA_WIDTH-1:0] read_value;
		logic [POS_W-1:0]      found_position;
		logic [POS_W-1:0]      list_length;
	} rsp_t;

	// Shift command broadcast to every cell for insert and delete.
	typedef struct packed {
		logic                  ins;
		logic                  del;
		logic [IDX_W-1:0]      at;
		logic [DATA_WIDTH-1:0] value;
	} shift_t;

	// Search probe handed from cell to cell for get and locate.
	typedef struct packed {
		logic                  active;
		logic                  get;
		logic [IDX_W-1:0]      target;
		logic [DATA_WIDTH-1:0] key;
		logic [CNT_W-1:0]      count;
		logic                  hit;
		logic [CNT_W-1:0]      hit_pos;
		logic [DATA_WIDTH-1:0] rd;
	} probe_t;

endpackage

@@ sv/ple_cell.sv @@
// One list cell: holds one entry, shifts with its neighbours and serves a passing probe.
module ple_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [ple_pkg::IDX_W-1:0]      idx,
	input  ple_pkg::shift_t                shift,
	input  logic [ple_pkg::DATA_WIDTH-1:0] left_data,
	input  logic [ple_pkg::DATA_WIDTH-1:0] right_data,
	output logic [ple_pkg::DATA_WIDTH-1:0] data,
	input  ple_pkg::probe_t                probe_in,
	output ple_pkg::probe_t                probe_out
);
	import ple_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	probe_t                probe_q;
	probe_t                probe_d;

	assign data      = data_q;
	assign probe_out = probe_q;

	// Entry storage: insert opens a gap at the target, delete closes it.
	always_ff @(posedge clk) begin
		if (shift.ins) begin
			if (idx == shift.at) begin
				data_q <= shift.value;
			end else if (idx > shift.at) begin
				data_q <= left_data;
			end
		end else if (shift.del && (idx >= shift.at)) begin
			data_q <= right_data;
		end
	end

	// The probe stops matching once an earlier cell has hit.
	always_comb begin
		probe_d = probe_in;
		if (probe_in.active && !probe_in.hit) begin
			if (probe_in.get) begin
				if (idx == probe_in.target) begin
					probe_d.hit = 1'b1;
					probe_d.rd  = data_q;
				end
			end else if ((CNT_W'(idx) < probe_in.count) && (data_q == probe_in.key)) begin
				probe_d.hit     = 1'b1;
				probe_d.hit_pos = CNT_W'(idx) + CNT_W'(1);
			end
		end
	end

	// Probe stage register towards the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
		end
	end

endmodule

@@ sv/positional_list_engine.sv @@
// Top level of the positional list engine: control, entry count and the row of cells.
// Insert, delete and any range or full error finish at once: when the output
// register is free, the response is registered in the cycle after the request item
// is taken, and the next request item can be taken in that same cycle; otherwise
// the result is held until the output register frees. Get and locate send a probe
// down the row of CAPACITY cells, one cell per cycle, and the result is held when it
// leaves the last cell. One operation is in progress at a time, and a response may
// wait in the output register while the following request item is being worked on.
module positional_list_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ple_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ple_pkg::rsp_t   rsp
);
	import ple_pkg::*;

	state_t                state_q;
	state_t                state_d;
	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	rsp_t                  rsp_q;
	rsp_t                  res_q;

	logic                  accept;
	logic                  slot_free;
	logic                  is_scan;
	logic                  load_out;
	logic                  res_load;
	rsp_t                  imm_res;
	rsp_t                  scan_res;
	rsp_t                  res_d;
	shift_t                shift;
	probe_t                launch;
	logic [IDX_W-1:0]      pos_idx;
	logic [CMP_W-1:0]      pos_ext;
	logic [CMP_W-1:0]      cnt_ext;

	logic [DATA_WIDTH-1:0] data_w  [CAPACITY];
	probe_t                probe_w [CAPACITY+1];

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign slot_free = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;
	assign pos_idx   = IDX_W'(req.position - POS_W'(1));
	assign pos_ext   = CMP_W'(req.position);
	assign cnt_ext   = CMP_W'(count_q);

	// Decode the request item and work out the immediate result.
	always_comb begin
		imm_res                = '0;
		imm_res.status         = STS_OK;
		imm_res.list_length    = POS_W'(count_q);
		is_scan                = 1'b0;
		shift                  = '0;
		shift.at               = pos_idx;
		shift.value            = req.value;
		unique case (req.kind)
			OP_INSERT: begin
				if ((pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1))) begin
					imm_res.status = STS_RANGE;
				end else if (cnt_ext == CMP_W'(CAPACITY)) begin
					imm_res.status = STS_FULL;
				end else begin
					shift.ins           = accept;
					imm_res.list_length = POS_W'(count_q + CNT_W'(1));
				end
			end
			OP_DELETE: begin
				if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
					imm_res.status = STS_RANGE;
				end else begin
					shift.del           = accept;
					imm_res.list_length = POS_W'(count_q - CNT_W'(1));
				end
			end
			OP_GET: begin
				if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
					imm_res.status = STS_RANGE;
				end else begin
					is_scan = 1'b1;
				end
			end
			default: begin
				is_scan = 1'b1;
			end
		endcase
	end

	// Probe launched into the first cell.
	always_comb begin
		launch        = '0;
		launch.active = accept && is_scan;
		launch.get    = (req.kind == OP_GET);
		launch.target = pos_idx;
		launch.key    = req.value;
		launch.count  = count_q;
	end

	assign probe_w[0] = launch;

	// The row of cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = data_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = data_w[i+1];
		end

		ple_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (IDX_W'(i)),
			.shift      (shift),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (data_w[i]),
			.probe_in   (probe_w[i]),
			.probe_out  (probe_w[i+1])
		);
	end

	// Result of a probe leaving the last cell.
	always_comb begin
		scan_res                = '0;
		scan_res.list_length    = POS_W'(probe_w[CAPACITY].count);
		if (probe_w[CAPACITY].hit) begin
			scan_res.status = STS_OK;
			if (probe_w[CAPACITY].get) begin
				scan_res.read_value = probe_w[CAPACITY].rd;
			end else begin
				scan_res.found_position = POS_W'(probe_w[CAPACITY].hit_pos);
			end
		end else begin
			scan_res.status = STS_NOT_FOUND;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_scan) begin
					state_d = ST_SCAN;
				end else if (accept && !slot_free) begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				if (probe_w[CAPACITY].active) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control outputs of the state machine.
	always_comb begin
		load_out = 1'b0;
		res_load = 1'b0;
		res_d    = imm_res;
		unique case (state_q)
			ST_IDLE: begin
				load_out = accept && !is_scan && slot_free;
				res_load = accept && !is_scan && !slot_free;
			end
			ST_SCAN: begin
				res_load = probe_w[CAPACITY].active;
				res_d    = scan_res;
			end
			ST_DONE: begin
				load_out = slot_free;
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (shift.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (shift.del) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Held result and output register.
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
		if (load_out) begin
			rsp_q <= (state_q == ST_DONE) ? res_q : imm_res;
		end
	end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the positional list engine.
module tb;
	import ple_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_ITEMS  = 1400;
	localparam int SETTLE_CYCLES = CAPACITY + 8;
	localparam int REPORT_LIMIT  = 10;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Shadow copy of the list, updated as each item is accepted.
	logic [DATA_WIDTH-1:0] shadow_entries [CAPACITY];
	int shadow_count = 0;

	// Replies still owed by the block, oldest first.
	rsp_t expected_replies [$];

	int mismatches      = 0;
	int replies_checked = 0;
	int cycle_count     = 0;
	int kind_seen [4]   = '{default: 0};
	int status_seen [4] = '{default: 0};

	// When set, neither side inserts random gaps.
	bit steady   = 1'b0;
	// A request to the reply side to hold off for this many cycles.
	int hold_ask = 0;

	positional_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the reply to one item and applies its effect to the shadow list.
	function automatic rsp_t list_outcome(req_t r);
		rsp_t o;
		int p;
		int k;
		o = '0;
		o.status = STS_OK;
		p = r.position;
		case (op_e_t'(r.kind))
			OP_INSERT: begin
				if (p < 1 || p > shadow_count + 1)
					o.status = STS_RANGE;
				else if (shadow_count >= CAPACITY)
					o.status = STS_FULL;
				else begin
					for (k = shadow_count; k > p - 1; k--)
						shadow_entries[k] = shadow_entries[k - 1];
					shadow_entries[p - 1] = r.value;
					shadow_count++;
				end
			end
			OP_DELETE: begin
				if (p < 1 || p > shadow_count)
					o.status = STS_RANGE;
				else begin
					for (k = p - 1; k + 1 < shadow_count; k++)
						shadow_entries[k] = shadow_entries[k + 1];
					shadow_count--;
				end
			end
			OP_GET: begin
				if (p < 1 || p > shadow_count)
					o.status = STS_RANGE;
				else
					o.read_value = shadow_entries[p - 1];
			end
			default: begin
				o.status = STS_NOT_FOUND;
				for (k = 0; k < shadow_count; k++) begin
					if (shadow_entries[k] == r.value) begin
						o.status = STS_OK;
						o.found_position = POS_W'(k + 1);
						break;
					end
				end
			end
		endcase
		o.list_length = POS_W'(shadow_count);
		return o;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("[%0d] MISMATCH: %s", cycle_count, what);
	endtask

	// Offers one item, holds it until it is taken and records the reply it owes.
	// Entered and left at a falling edge.
	task automatic send_request(input op_e_t kind, input int position,
			input logic [DATA_WIDTH-1:0] value);
		req_t r;
		rsp_t o;
		r.kind     = kind;
		r.position = POS_W'(position);
		r.value    = value;
		while (!steady && $urandom_range(99) < 25) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		o = list_outcome(r);
		expected_replies.push_back(o);
		kind_seen[kind]++;
		status_seen[o.status]++;
		@(negedge clk);
	endtask

	// Stops offering items until every owed reply has come back.
	task automatic wait_replies_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (expected_replies.size() != 0);
	endtask

	// Draws one item; growing favours inserts, otherwise deletes dominate.
	task automatic send_random_item(input bit growing);
		int roll;
		int span;
		int pos;
		op_e_t kind;
		logic [DATA_WIDTH-1:0] value;
		roll = $urandom_range(99);
		if (roll < 55)
			kind = growing ? OP_INSERT : OP_DELETE;
		else if (roll < 65)
			kind = growing ? OP_DELETE : OP_INSERT;
		else if (roll < 80)
			kind = OP_GET;
		else
			kind = OP_LOCATE;

		// Mostly positions within range, with some noise from 0 to CAPACITY + 1.
		if ($urandom_range(99) < 85) begin
			span = (kind == OP_INSERT) ? shadow_count + 1 : shadow_count;
			pos  = (span > 0) ? $urandom_range(span, 1) : 1;
		end else
			pos = $urandom_range(CAPACITY + 1, 0);

		// A small pool of values makes duplicates common.
		roll = $urandom_range(99);
		if (roll < 20)
			value = $urandom_range(7);
		else if (roll < 30)
			value = $urandom_range(1) ? '1 : '0;
		else
			value = $urandom;
		if (kind == OP_LOCATE && shadow_count > 0 && $urandom_range(99) < 70)
			value = shadow_entries[$urandom_range(shadow_count - 1)];

		send_request(kind, pos, value);
	endtask

	// Empty-list errors, edge positions, extreme values and duplicate search.
	task automatic test_directed_cases();
		send_request(OP_GET, 1, '0);
		send_request(OP_DELETE, 1, '0);
		send_request(OP_LOCATE, 0, '0);
		send_request(OP_INSERT, 0, 32'h1111_1111);
		send_request(OP_INSERT, 2, 32'h2222_2222);
		send_request(OP_INSERT, 1, '1);
		send_request(OP_INSERT, 2, '0);
		send_request(OP_INSERT, 1, 32'hA5A5_A5A5);
		send_request(OP_INSERT, 2, 32'h5A5A_5A5A);
		send_request(OP_GET, 1, '0);
		send_request(OP_GET, 4, '0);
		// Reading one past the end must be refused.
		send_request(OP_GET, 5, '0);
		send_request(OP_GET, 0, '0);
		send_request(OP_GET, CAPACITY + 1, '0);
		send_request(OP_LOCATE, 0, '0);
		// A second zero at the head: the lowest match must win.
		send_request(OP_INSERT, 1, '0);
		send_request(OP_LOCATE, 0, '0);
		send_request(OP_LOCATE, 0, 32'h1234_5678);
		send_request(OP_DELETE, 0, '0);
		send_request(OP_DELETE, CAPACITY, '0);
		send_request(OP_DELETE, 5, '0);
		send_request(OP_DELETE, 1, '0);
		send_request(OP_DELETE, 2, '0);
		send_request(OP_INSERT, CAPACITY + 1, '1);
		send_request(OP_GET, 2, '0);
	endtask

	// Fills the list, then probes the full condition and the range check before it.
	task automatic test_fill_to_capacity();
		while (shadow_count < CAPACITY)
			send_request(OP_INSERT, $urandom_range(shadow_count + 1, 1), $urandom);
		send_request(OP_INSERT, 1, '1);
		send_request(OP_INSERT, CAPACITY + 1, '0);
		send_request(OP_INSERT, CAPACITY / 2, 32'h0F0F_0F0F);
		send_request(OP_INSERT, 0, 32'h0F0F_0F0F);
		send_request(OP_GET, CAPACITY, '0);
		send_request(OP_GET, CAPACITY + 1, '0);
		send_request(OP_LOCATE, 0, shadow_entries[CAPACITY - 1]);
		send_request(OP_DELETE, CAPACITY, '0);
		send_request(OP_INSERT, CAPACITY, 32'hC3C3_C3C3);
		send_request(OP_DELETE, 1, '0);
	endtask

	// The reply side holds off for a long stretch while items keep coming.
	task automatic test_output_backpressure();
		int n;
		steady   = 1'b1;
		hold_ask = 300;
		for (n = 0; n < 30; n++)
			send_random_item(n < 15);
		steady = 1'b0;
	endtask

	// Long random run swinging between growing and shrinking the list.
	task automatic test_random_mix();
		int n;
		bit growing;
		growing = 1'b1;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 400 && n < 600);
			if (n == 900)
				wait_replies_drained();
			if (shadow_count == CAPACITY && $urandom_range(9) == 0)
				growing = 1'b0;
			else if (shadow_count == 0)
				growing = 1'b1;
			send_random_item(growing);
		end
		steady = 1'b0;
	endtask

	// Reply side: random gaps, or a long hold-off when one is asked for.
	always begin : reply_acceptor
		int hold_left;
		@(negedge clk);
		if (hold_ask > 0) begin
			hold_left = hold_ask;
			hold_ask  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (!steady && $urandom_range(99) < 25)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= 1'b1;
	end

	// Compares each reply taken with the oldest one owed.
	always @(posedge clk) begin : reply_checker
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_replies.size() == 0)
				flag_mismatch($sformatf("reply with none owed: st=%0d rd=%h pos=%0d len=%0d",
					rsp.status, rsp.read_value, rsp.found_position, rsp.list_length));
			else begin
				want = expected_replies.pop_front();
				replies_checked++;
				if (rsp.status !== want.status || rsp.read_value !== want.read_value ||
						rsp.found_position !== want.found_position ||
						rsp.list_length !== want.list_length)
					flag_mismatch($sformatf(
						"expected st=%0d rd=%h pos=%0d len=%0d, got st=%0d rd=%h pos=%0d len=%0d",
						want.status, want.read_value, want.found_position, want.list_length,
						rsp.status, rsp.read_value, rsp.found_position, rsp.list_length));
			end
		end
	end

	// Guards against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d replies outstanding.",
				CYCLE_LIMIT, expected_replies.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		wait_replies_drained();
		test_fill_to_capacity();
		wait_replies_drained();
		test_output_backpressure();
		wait_replies_drained();
		test_random_mix();

		// Let the last replies out, then watch for any stray ones.
		req_valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_replies.size() != 0)
			flag_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));

		$display("Items sent: %0d insert, %0d delete, %0d get, %0d locate; %0d replies checked.",
			kind_seen[OP_INSERT], kind_seen[OP_DELETE], kind_seen[OP_GET],
			kind_seen[OP_LOCATE], replies_checked);
		$display("Outcomes: %0d ok, %0d out of range, %0d full, %0d not found; %0d mismatches.",
			status_seen[STS_OK], status_seen[STS_RANGE], status_seen[STS_FULL],
			status_seen[STS_NOT_FOUND], mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ files.f @@
sv/ple_pkg.sv
sv/ple_cell.sv
sv/positional_list_engine.sv
dv/tb.sv
